// ===== rtl/six_bit_frame_decoder_assert.svh =====
// Assertion macros shared by the six-bit frame decoder RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef SIX_BIT_FRAME_DECODER_ASSERT_SVH
`define SIX_BIT_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SBFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sbfd_pkg.sv =====
// Package of the six-bit frame decoder: types, register indexes and constants.
// Used by the interfaces and every module of the block; depends on nothing.
`default_nettype none

package sbfd_pkg;

	// Field widths of the channels.
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 7;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 8;

	// Default frame length limit.
	localparam int unsigned MAX_FRAME_BYTES_DEF = 64;

	// Offset removed from every data character.
	localparam logic [CHAR_W-1:0] CHAR_BIAS = 8'h40;

	// Register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 8'd1;
	localparam logic [CHAR_W-1:0]    START_CHAR_RST = 8'd9;
	localparam logic [CHAR_W-1:0]    END_CHAR_RST   = 8'd10;

	// Decoder phase: idle, then the four character slots of a group.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SLOT1 = 3'd1,
		PH_SLOT2 = 3'd2,
		PH_SLOT3 = 3'd3,
		PH_SLOT4 = 3'd4
	} phase_t;

	// Configuration as seen by the decoder.
	typedef struct packed {
		logic [CHAR_W-1:0] start_char;
		logic [CHAR_W-1:0] end_char;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic              is_frame_end;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  frame_length;
		logic              overflowed;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/sbfd_char_if.sv =====
// Request channel carrying received characters into the decoder.
// Depends on sbfd_pkg for field widths.
`default_nettype none

interface sbfd_char_if
	import sbfd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbfd_res_if.sv =====
// Request channel carrying decoded bytes and frame-end records out.
// Depends on sbfd_pkg for field widths.
`default_nettype none

interface sbfd_res_if
	import sbfd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              is_frame_end;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0]  frame_length;
	logic              overflowed;

	modport source (output valid, output is_frame_end, output data_byte,
		output frame_length, output overflowed, input ready);
	modport sink   (input valid, input is_frame_end, input data_byte,
		input frame_length, input overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbfd_cfg_if.sv =====
// Register write channel: index and write data with a valid/ready pair.
// Depends on sbfd_pkg for field widths.
`default_nettype none

interface sbfd_cfg_if
	import sbfd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/six_bit_frame_decoder.sv =====
// Top level of the six-bit frame decoder: registers, decoder core, result register.
// Depends on sbfd_pkg, the three channel interfaces and the sbfd_* modules.
//
//  Channel | Role | Payload                                            | Request taken when
//  rx      | sink | rx_char                                            | rx.valid & rx.ready
//  res     | src  | is_frame_end, data_byte, frame_length, overflowed  | res.valid & res.ready
//  cfg     | sink | index, data                                        | cfg.valid & cfg.ready
//
// One character is taken per cycle while the result channel does not stall; its result,
// if any, is offered once the character has passed the input register, then the result register.
// The single result register sets the rate: rx.ready falls only while a result waits
// and is not taken, so a stalled result channel holds one character in the input stage.
// arst_n clears the phase, counters, valid flags and restores both start/end characters.
// cfg.ready is always high; register writes take effect on the next cycle.
`default_nettype none

module six_bit_frame_decoder
	import sbfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbfd_char_if.sink  rx,
	sbfd_res_if.source res,
	sbfd_cfg_if.sink   cfg
);

	cfg_t regs;
	logic res_free;
	logic res_load;
	res_t res_d;

	// Start and end character registers.
	sbfd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Character decoding and frame tracking.
	sbfd_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.regs     (regs),
		.res_free (res_free),
		.res_load (res_load),
		.res_d    (res_d)
	);

	// Result holding register.
	sbfd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res_d    (res_d),
		.res_free (res_free),
		.res      (res)
	);

endmodule

`default_nettype wire

// ===== rtl/sbfd_cfg_regs.sv =====
// Configuration registers of the six-bit frame decoder (start and end characters).
// Depends on sbfd_pkg and the sbfd_cfg_if interface.
`default_nettype none

module sbfd_cfg_regs
	import sbfd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbfd_cfg_if.sink   cfg,
	output cfg_t       regs
);

	logic [CHAR_W-1:0] start_char_q;
	logic [CHAR_W-1:0] end_char_q;
	logic              wr_en;

	// Writes are always taken; unknown indexes are dropped.
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RST;
			end_char_q   <= END_CHAR_RST;
		end else if (wr_en) begin
			case (cfg.index)
				REG_START_CHAR: start_char_q <= cfg.data[CHAR_W-1:0];
				REG_END_CHAR:   end_char_q   <= cfg.data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs.start_char = start_char_q;
	assign regs.end_char   = end_char_q;

endmodule

`default_nettype wire

// ===== rtl/sbfd_core.sv =====
// Decoder core: input register, phase state machine and byte reassembly.
// Depends on sbfd_pkg, sbfd_char_if and the assertion macro header.
`default_nettype none
`include "six_bit_frame_decoder_assert.svh"

module sbfd_core
	import sbfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbfd_char_if.sink  rx,
	input  wire cfg_t  regs,
	input  wire logic  res_free,
	output logic       res_load,
	output res_t       res_d
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

	// Input stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] rx_char_s1;
	logic              fire;

	// Frame state.
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] partial_q, partial_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              ovf_q, ovf_d;

	// Decode signals.
	logic [CHAR_W-1:0]      v;
	logic                   is_start;
	logic                   is_end;
	logic                   byte_done;
	logic [BYTE_W-1:0]      byte_val;
	logic                   room;
	logic [CNT_W+LEN_W-1:0] len_ext;

	// The held character moves on when the result register can take its result.
	assign fire     = valid_s1 & res_free;
	assign rx.ready = ~valid_s1 | res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_char_s1 <= rx.rx_char;
		end
	end

	// Character classification and six-bit value.
	assign v        = rx_char_s1 - CHAR_BIAS;
	assign is_start = (rx_char_s1 == regs.start_char);
	assign is_end   = (rx_char_s1 == regs.end_char);
	assign room     = (count_q < CNT_MAX);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			case (phase_q)
				PH_IDLE:  phase_d = is_start ? PH_SLOT1 : PH_IDLE;
				PH_SLOT1: phase_d = is_end ? PH_IDLE : PH_SLOT2;
				PH_SLOT2: phase_d = is_end ? PH_IDLE : PH_SLOT3;
				PH_SLOT3: phase_d = is_end ? PH_IDLE : PH_SLOT4;
				PH_SLOT4: phase_d = is_end ? PH_IDLE : PH_SLOT1;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	// Byte reassembly: six bits per slot, most significant bits first.
	always_comb begin
		partial_d = partial_q;
		byte_done = 1'b0;
		byte_val  = '0;
		if (fire) begin
			if (phase_q == PH_IDLE) begin
				if (is_start) begin
					partial_d = '0;
				end
			end else if (is_end) begin
				partial_d = '0;
			end else begin
				case (phase_q)
					PH_SLOT1: begin
						partial_d = {v[5:0], 2'b00};
					end
					PH_SLOT2: begin
						byte_done = 1'b1;
						byte_val  = {partial_q[7:2], v[5:4]};
						partial_d = {v[3:0], 4'b0000};
					end
					PH_SLOT3: begin
						byte_done = 1'b1;
						byte_val  = {partial_q[7:4], v[5:2]};
						partial_d = {v[1:0], 6'b000000};
					end
					PH_SLOT4: begin
						byte_done = 1'b1;
						byte_val  = {partial_q[7:6], v[5:0]};
						partial_d = '0;
					end
					default: partial_d = '0;
				endcase
			end
		end
	end

	// Byte count, overflow flag and the result going to the output register.
	assign len_ext = (CNT_W + LEN_W)'(count_q);

	always_comb begin
		count_d  = count_q;
		ovf_d    = ovf_q;
		res_load = 1'b0;
		res_d    = '0;
		if (fire) begin
			if (phase_q == PH_IDLE) begin
				if (is_start) begin
					count_d = '0;
					ovf_d   = 1'b0;
				end
			end else if (is_end) begin
				res_load           = (count_q != '0);
				res_d.is_frame_end = 1'b1;
				res_d.frame_length = len_ext[LEN_W-1:0];
				res_d.overflowed   = ovf_q;
			end else if (byte_done) begin
				if (room) begin
					count_d         = count_q + CNT_W'(1);
					res_load        = 1'b1;
					res_d.data_byte = byte_val;
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			partial_q <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			partial_q <= partial_d;
			count_q   <= count_d;
			ovf_q     <= ovf_d;
		end
	end

	// The byte count never passes the frame limit.
	`SBFD_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_MAX, "byte count above limit")
	// Overflow is only recorded once the frame is full.
	`SBFD_ASSERT_NOW(a_ovf_full, clk, arst_n, ovf_q, count_q == CNT_MAX, "overflow before frame full")
	// Nothing is emitted for a character seen while idle.
	`SBFD_ASSERT_NOW(a_idle_silent, clk, arst_n, fire && phase_q == PH_IDLE, !res_load, "result while idle")
	// A start character taken while idle opens a frame with a cleared count.
	`SBFD_ASSERT_NEXT(a_idle_open, clk, arst_n, fire && phase_q == PH_IDLE && is_start, phase_q == PH_SLOT1 && count_q == '0, "frame did not open")

endmodule

`default_nettype wire

// ===== rtl/sbfd_out_reg.sv =====
// Result register of the six-bit frame decoder, driving the result channel.
// Depends on sbfd_pkg and the sbfd_res_if interface.
`default_nettype none

module sbfd_out_reg
	import sbfd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  res_load,
	input  wire res_t  res_d,
	output logic       res_free,
	sbfd_res_if.source res
);

	logic valid_q;
	res_t data_q;

	// The register is free when empty or being drained this cycle.
	assign res_free = ~valid_q | res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_load) begin
			data_q <= res_d;
		end
	end

	assign res.valid        = valid_q;
	assign res.is_frame_end = data_q.is_frame_end;
	assign res.data_byte    = data_q.data_byte;
	assign res.frame_length = data_q.frame_length;
	assign res.overflowed   = data_q.overflowed;

endmodule

`default_nettype wire
